[design/ehd_pkg.sv]
// ----------------------------------------------------------------------------
// ehd_pkg: extendible hash directory package
// Request and status codes, FSM state type, field widths and defaults.
// ----------------------------------------------------------------------------
package ehd_pkg;

  localparam int unsigned DIR_ENTRIES_DEF = 512;
  localparam int unsigned DEPTH_LIMIT_DEF = 9;

  localparam int REQ_W  = 4;
  localparam int HASH_W = 32;
  localparam int IDX_W  = 9;
  localparam int PID_W  = 32;
  localparam int LD_W   = 4;
  localparam int STS_W  = 2;

  localparam logic [LD_W-1:0] GROW_LIM_RST = LD_W'(9);

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR      = 4'd0,
    REQ_LOOKUP     = 4'd1,
    REQ_READ       = 4'd2,
    REQ_WRITE_ID   = 4'd3,
    REQ_SET_LD     = 4'd4,
    REQ_INC_LD     = 4'd5,
    REQ_DEC_LD     = 4'd6,
    REQ_GROW       = 4'd7,
    REQ_SHRINK     = 4'd8,
    REQ_CAN_SHRINK = 4'd9
  } req_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_LIMIT = 2'd2
  } sts_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_GROW,
    ST_SCAN,
    ST_FIN
  } state_e;

endpackage

[design/extendible_hash_directory_core.sv]
// Single-slot requests (lookup, read, write id, local depth ops, shrink) strobe
//   done_o when finished; busy stays high until then, so no new item is taken before.
// Grow (below the cap) and can-shrink (global depth above zero) walk the live
//   directory slot by slot through the single read port of the directory memories.
// Clear rewrites every entry. After reset a clearing pass runs with busy high;
//   the receiver cannot stall results.
// ----------------------------------------------------------------------------
// extendible_hash_directory_core: extendible hashing directory
// Page id and local depth per slot in two synchronous memories, plus global
// depth; lookup, slot access, local depth update, grow, shrink, clear.
// ----------------------------------------------------------------------------
module extendible_hash_directory_core
  import ehd_pkg::*;
#(
  parameter int unsigned DIR_ENTRIES = DIR_ENTRIES_DEF,
  parameter int unsigned DEPTH_LIMIT = DEPTH_LIMIT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // command handshake
  input  logic                    start,
  output logic                    busy,
  output logic                    done_o,
  // configuration: global depth ceiling
  input  logic                    cfg_we_i,
  input  logic [LD_W-1:0]         cfg_wdata_i,
  // request item
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic [HASH_W-1:0]       hash_i,
  input  logic [IDX_W-1:0]        bucket_index_i,
  input  logic signed [PID_W-1:0] page_id_i,
  input  logic [LD_W-1:0]         local_depth_i,
  // result item
  output logic [STS_W-1:0]        status_o,
  output logic [IDX_W-1:0]        out_slot_o,
  output logic signed [PID_W-1:0] out_page_id_o,
  output logic [LD_W-1:0]         out_local_depth_o,
  output logic [IDX_W-1:0]        split_image_o,
  output logic [LD_W-1:0]         cur_global_depth_o,
  output logic                    shrink_ok_o
);

  // Memory address width and a width wide enough for both the index port
  // and the table address, used for range checks.
  localparam int AW  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int IW  = (AW > IDX_W) ? AW : IDX_W;
  localparam int IWP = IW + 1;
  // Largest depth whose directory still fits in the table.
  localparam int unsigned FIT_DEPTH = $clog2(DIR_ENTRIES + 1) - 1;
  localparam int unsigned CAP_HW    = (DEPTH_LIMIT < FIT_DEPTH) ? DEPTH_LIMIT : FIT_DEPTH;
  localparam logic [AW-1:0] LAST_ENTRY = AW'(DIR_ENTRIES - 1);

  // ---------------------------------------------------------------------------
  // Directory memories: one write port, one registered read port each.
  // ---------------------------------------------------------------------------
  logic [PID_W-1:0] pid_mem [DIR_ENTRIES];
  logic [LD_W-1:0]  ld_mem  [DIR_ENTRIES];

  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             pid_we, ld_we;
  logic [PID_W-1:0] pid_wdata;
  logic [LD_W-1:0]  ld_wdata;
  logic [PID_W-1:0] pid_rd_q;
  logic [LD_W-1:0]  ld_rd_q;

  always_ff @(posedge clk_i) begin
    if (pid_we) begin
      pid_mem[wr_addr] <= pid_wdata;
    end
    if (ld_we) begin
      ld_mem[wr_addr] <= ld_wdata;
    end
    pid_rd_q <= pid_mem[rd_addr];
    ld_rd_q  <= ld_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e          state_q, state_d;
  logic [AW-1:0]   cnt_q, cnt_d;       // clearing pass / walk position
  logic [LD_W-1:0] gd_q, gd_d;         // global depth
  logic [LD_W-1:0] grow_lim_q;         // configured global depth ceiling
  logic            ok_q, ok_d;         // can-shrink running answer
  logic            walk_vld_q;         // read data belongs to a walk read
  logic            walk_vld_d;
  logic [AW-1:0]   walk_addr_q;
  logic            clr_req_q;          // clearing pass was requested, not reset
  logic            done_q;

  // captured request
  req_e            req_q;
  logic [IDX_W-1:0] idx_q;             // slot as reported
  logic [AW-1:0]   addr_q;             // slot as memory address
  logic [PID_W-1:0] pid_in_q;
  logic [LD_W-1:0] ldin_q;
  logic            in_tbl_q;           // slot inside the table
  logic            in_rng_q;           // slot inside the current directory

  // result
  logic            fin;
  sts_e            res_sts;
  logic [IDX_W-1:0] res_slot;
  logic [PID_W-1:0] res_pid;
  logic [LD_W-1:0] res_ld;
  logic            res_ok;
  logic [IDX_W-1:0] res_split;
  logic [IDX_W-1:0] split_bit;

  // ---------------------------------------------------------------------------
  // Request decode at accept
  // ---------------------------------------------------------------------------
  logic            acc;
  req_e            req_in;
  logic [AW-1:0]   gd_mask;            // current directory size minus one
  logic [AW-1:0]   look_slot;
  logic [IW-1:0]   idx_ext;
  logic [AW-1:0]   acc_addr;
  logic            acc_in_tbl;
  logic            acc_in_rng;
  logic [LD_W-1:0] cap;
  logic [AW-1:0]   upper_base;

  assign busy      = (state_q != ST_IDLE);
  assign acc       = start && !busy;
  assign req_in    = req_e'(req_type_i);
  assign gd_mask   = ~({AW{1'b1}} << gd_q);
  assign look_slot = AW'(hash_i) & gd_mask;
  assign idx_ext   = IW'(bucket_index_i);
  assign acc_addr  = (req_in == REQ_LOOKUP) ? look_slot : AW'(idx_ext);
  assign acc_in_tbl = ({1'b0, idx_ext} < IWP'(DIR_ENTRIES));
  assign acc_in_rng = ((idx_ext >> gd_q) == '0);
  assign cap        = (grow_lim_q > LD_W'(CAP_HW)) ? LD_W'(CAP_HW) : grow_lim_q;
  // grow copies slot i into slot i + size; size is a single bit here
  assign upper_base = AW'(1) << gd_q;

  // ---------------------------------------------------------------------------
  // Next state, memory control and result
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    gd_d       = gd_q;
    ok_d       = ok_q;
    walk_vld_d = 1'b0;
    rd_addr    = cnt_q;
    wr_addr    = addr_q;
    pid_we     = 1'b0;
    ld_we      = 1'b0;
    pid_wdata  = pid_in_q;
    ld_wdata   = ld_rd_q;
    fin        = 1'b0;
    res_sts    = STS_OK;
    res_slot   = '0;
    res_pid    = '1;
    res_ld     = '0;
    res_ok     = 1'b0;

    // walk data arrives in the cycle after its read
    if (walk_vld_q) begin
      if (req_q == REQ_GROW) begin
        wr_addr   = walk_addr_q | upper_base;
        pid_we    = 1'b1;
        ld_we     = 1'b1;
        pid_wdata = pid_rd_q;
        ld_wdata  = ld_rd_q;
      end else if (ld_rd_q >= gd_q) begin
        ok_d = 1'b0;
      end
    end

    unique case (state_q)
      ST_CLEAR: begin
        wr_addr   = cnt_q;
        pid_we    = 1'b1;
        ld_we     = 1'b1;
        pid_wdata = '1;
        ld_wdata  = '0;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == LAST_ENTRY) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
          fin     = clr_req_q;
        end
      end

      ST_IDLE: begin
        rd_addr = acc_addr;
        if (acc) begin
          cnt_d = '0;
          ok_d  = 1'b1;
          unique case (req_in)
            REQ_CLEAR: begin
              state_d = ST_CLEAR;
              gd_d    = '0;
            end
            REQ_GROW:       state_d = (gd_q < cap) ? ST_GROW : ST_EXEC;
            REQ_CAN_SHRINK: state_d = (gd_q != '0) ? ST_SCAN : ST_EXEC;
            default:        state_d = ST_EXEC;
          endcase
        end
      end

      ST_EXEC: begin
        fin     = 1'b1;
        state_d = ST_IDLE;
        unique case (req_q)
          REQ_LOOKUP: begin
            res_slot = idx_q;
            res_pid  = pid_rd_q;
            res_ld   = ld_rd_q;
          end
          REQ_READ: begin
            res_slot = idx_q;
            res_sts  = in_rng_q ? STS_OK : STS_RANGE;
            if (in_tbl_q) begin
              res_pid = pid_rd_q;
              res_ld  = ld_rd_q;
            end
          end
          REQ_WRITE_ID: begin
            res_slot = idx_q;
            if (in_tbl_q) begin
              pid_we    = 1'b1;
              pid_wdata = pid_in_q;
              res_pid   = pid_in_q;
              res_ld    = ld_rd_q;
            end else begin
              res_sts = STS_RANGE;
            end
          end
          REQ_SET_LD, REQ_INC_LD, REQ_DEC_LD: begin
            res_slot = idx_q;
            if (!in_rng_q) begin
              res_sts = STS_RANGE;
              if (in_tbl_q) begin
                res_pid = pid_rd_q;
                res_ld  = ld_rd_q;
              end
            end else begin
              res_pid  = pid_rd_q;
              res_ld   = ld_rd_q;
              if (req_q == REQ_SET_LD) begin
                if (ldin_q > cap) begin
                  res_ld  = cap;
                  res_sts = STS_LIMIT;
                end else begin
                  res_ld = ldin_q;
                end
              end else if (req_q == REQ_INC_LD) begin
                if (ld_rd_q >= cap) begin
                  res_sts = STS_LIMIT;
                end else begin
                  res_ld = ld_rd_q + LD_W'(1);
                end
              end else if (ld_rd_q != '0) begin
                res_ld = ld_rd_q - LD_W'(1);
              end
              ld_we    = 1'b1;
              ld_wdata = res_ld;
            end
          end
          REQ_GROW: res_sts = STS_LIMIT;        // only reaches here at the cap
          REQ_SHRINK: begin
            if (gd_q == '0) begin
              res_sts = STS_LIMIT;
            end else begin
              gd_d = gd_q - LD_W'(1);
            end
          end
          default: ;                            // empty directory can-shrink, unused codes
        endcase
      end

      ST_GROW, ST_SCAN: begin
        walk_vld_d = 1'b1;
        cnt_d      = cnt_q + AW'(1);
        if (cnt_q == gd_mask) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        fin     = 1'b1;
        state_d = ST_IDLE;
        if (req_q == REQ_GROW) begin
          gd_d = gd_q + LD_W'(1);
        end else begin
          res_ok = ok_d;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign split_bit = (res_ld == '0) ? '0 : (IDX_W'(1) << (res_ld - LD_W'(1)));
  assign res_split = (res_ld == '0) ? '0 : (res_slot ^ split_bit);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      gd_q        <= '0;
      grow_lim_q  <= GROW_LIM_RST;
      ok_q        <= 1'b0;
      walk_vld_q  <= 1'b0;
      clr_req_q   <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      gd_q       <= gd_d;
      ok_q       <= ok_d;
      walk_vld_q <= walk_vld_d;
      done_q     <= fin;
      if (cfg_we_i) begin
        grow_lim_q <= cfg_wdata_i;
      end
      if (acc) begin
        clr_req_q <= (req_in == REQ_CLEAR);
      end
    end
  end

  // request capture and result register, no reset needed
  always_ff @(posedge clk_i) begin
    walk_addr_q <= cnt_q;
    if (acc) begin
      req_q    <= req_in;
      addr_q   <= acc_addr;
      idx_q    <= (req_in == REQ_LOOKUP) ? IDX_W'(look_slot) : bucket_index_i;
      pid_in_q <= page_id_i;
      ldin_q   <= local_depth_i;
      in_tbl_q <= (req_in == REQ_LOOKUP) || acc_in_tbl;
      in_rng_q <= (req_in == REQ_LOOKUP) || acc_in_rng;
    end
    if (fin) begin
      status_o           <= res_sts;
      out_slot_o         <= res_slot;
      out_page_id_o      <= res_pid;
      out_local_depth_o  <= res_ld;
      split_image_o      <= res_split;
      cur_global_depth_o <= gd_d;
      shrink_ok_o        <= res_ok;
    end
  end

  assign done_o = done_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_gd_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gd_q <= LD_W'(CAP_HW))
    else $error("global depth beyond table capacity");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_EXEC || state_q == ST_FIN || state_q == ST_CLEAR))
    else $error("result strobe without work");

  a_result_on_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && $past(state_q == ST_EXEC || state_q == ST_FIN) |-> done_q)
    else $error("request finished without result");

  a_copy_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_vld_q |-> (state_q == ST_GROW || state_q == ST_SCAN || state_q == ST_FIN))
    else $error("walk data outside a walk");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: extendible hash directory core testbench
// Drives request items through the start/busy handshake, predicts every reply
// with a behavioral copy of the directory (page ids, local depths, global
// depth, depth ceiling), and checks each done_o strobe against the oldest
// prediction. Directed edge cases first, then random traffic over several
// ceiling settings.
// ----------------------------------------------------------------------------
module tb_top;
  import ehd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIR_ENTRIES = DIR_ENTRIES_DEF;
  localparam int unsigned DEPTH_LIMIT = DEPTH_LIMIT_DEF;

  // Codes outside the defined set decode to no operation.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 4'd10;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 4'd15;

  localparam logic signed [PID_W-1:0] PID_INVALID = -32'sd1;

  // Longest quiet stretch: a clear pass or a full-size grow plus the sender's
  // longest gap, taken eight times over.
  localparam int QUIET_LIMIT = 8 * (DIR_ENTRIES + 2 + 18);
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [REQ_W-1:0]        req;
    logic [HASH_W-1:0]       hash;
    logic [IDX_W-1:0]        idx;
    logic signed [PID_W-1:0] pid;
    logic [LD_W-1:0]         ld;
  } dir_req_t;

  typedef struct {
    logic [REQ_W-1:0]        req;     // for reporting only
    logic [STS_W-1:0]        sts;
    logic [IDX_W-1:0]        slot;
    logic signed [PID_W-1:0] pid;
    logic [LD_W-1:0]         ld;
    logic [IDX_W-1:0]        split;
    logic [LD_W-1:0]         gd;
    logic                    ok;
  } dir_reply_t;

  // DUT signals
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    done_o;
  logic                    cfg_we_i = 1'b0;
  logic [LD_W-1:0]         cfg_wdata_i = '0;
  logic [REQ_W-1:0]        req_type_i = '0;
  logic [HASH_W-1:0]       hash_i = '0;
  logic [IDX_W-1:0]        bucket_index_i = '0;
  logic signed [PID_W-1:0] page_id_i = '0;
  logic [LD_W-1:0]         local_depth_i = '0;
  logic [STS_W-1:0]        status_o;
  logic [IDX_W-1:0]        out_slot_o;
  logic signed [PID_W-1:0] out_page_id_o;
  logic [LD_W-1:0]         out_local_depth_o;
  logic [IDX_W-1:0]        split_image_o;
  logic [LD_W-1:0]         cur_global_depth_o;
  logic                    shrink_ok_o;

  // Shadow directory
  logic signed [PID_W-1:0] m_pid [DIR_ENTRIES];
  logic [LD_W-1:0]         m_ld [DIR_ENTRIES];
  logic [LD_W-1:0]         m_gd;
  logic [LD_W-1:0]         m_grow_lim;

  dir_reply_t dir_reply_q[$];
  int         err_cnt = 0;
  int         quiet_cycles = 0;
  bit         burst_mode = 1'b0;

  extendible_hash_directory_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .done_o             (done_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .req_type_i         (req_type_i),
    .hash_i             (hash_i),
    .bucket_index_i     (bucket_index_i),
    .page_id_i          (page_id_i),
    .local_depth_i      (local_depth_i),
    .status_o           (status_o),
    .out_slot_o         (out_slot_o),
    .out_page_id_o      (out_page_id_o),
    .out_local_depth_o  (out_local_depth_o),
    .split_image_o      (split_image_o),
    .cur_global_depth_o (cur_global_depth_o),
    .shrink_ok_o        (shrink_ok_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Directory model
  // ---------------------------------------------------------------------------
  function automatic void clear_directory();
    for (int i = 0; i < DIR_ENTRIES; i++) begin
      m_pid[i] = PID_INVALID;
      m_ld[i]  = '0;
    end
    m_gd = '0;
  endfunction

  // Effective depth cap: the ceiling bounded by the limit and the table size.
  function automatic logic [LD_W-1:0] depth_cap();
    int unsigned c;
    c = (m_grow_lim > DEPTH_LIMIT) ? DEPTH_LIMIT : m_grow_lim;
    while (c > 0 && (1 << c) > DIR_ENTRIES) c--;
    return LD_W'(c);
  endfunction

  function automatic dir_reply_t slot_view(dir_reply_t y, logic [IDX_W-1:0] slot);
    y.slot  = slot;
    y.pid   = m_pid[slot];
    y.ld    = m_ld[slot];
    y.split = (y.ld != 0) ? (slot ^ (IDX_W'(1) << (y.ld - 1))) : '0;
    return y;
  endfunction

  // Applies one request to the shadow directory, returns the reply it causes.
  function automatic dir_reply_t apply_dir_request(dir_req_t r);
    dir_reply_t      y;
    int unsigned     size;
    logic [LD_W-1:0] cap;
    size = 1 << m_gd;
    cap  = depth_cap();
    y = '{req: r.req, sts: STS_OK, slot: '0, pid: PID_INVALID, ld: '0,
          split: '0, gd: '0, ok: 1'b0};
    case (r.req)
      REQ_CLEAR: clear_directory();
      REQ_LOOKUP: y = slot_view(y, r.hash[IDX_W-1:0] & IDX_W'(size - 1));
      REQ_READ: begin
        if (r.idx >= size) y.sts = STS_RANGE;
        y = slot_view(y, r.idx);
      end
      REQ_WRITE_ID: begin
        // written even beyond the live size
        m_pid[r.idx] = r.pid;
        y = slot_view(y, r.idx);
      end
      REQ_SET_LD, REQ_INC_LD, REQ_DEC_LD: begin
        if (r.idx >= size) begin
          y.sts = STS_RANGE;
        end else if (r.req == REQ_SET_LD) begin
          if (r.ld > cap) begin
            m_ld[r.idx] = cap;
            y.sts = STS_LIMIT;
          end else begin
            m_ld[r.idx] = r.ld;
          end
        end else if (r.req == REQ_INC_LD) begin
          if (m_ld[r.idx] >= cap) y.sts = STS_LIMIT;  // saturates
          else m_ld[r.idx] = m_ld[r.idx] + 1'b1;
        end else begin
          if (m_ld[r.idx] > 0) m_ld[r.idx] = m_ld[r.idx] - 1'b1;
        end
        y = slot_view(y, r.idx);
      end
      REQ_GROW: begin
        if (m_gd >= cap) begin
          y.sts = STS_LIMIT;
        end else begin
          for (int i = 0; i < size; i++) begin
            m_pid[i + size] = m_pid[i];
            m_ld[i + size]  = m_ld[i];
          end
          m_gd = m_gd + 1'b1;
        end
      end
      REQ_SHRINK: begin
        if (m_gd == 0) y.sts = STS_LIMIT;
        else m_gd = m_gd - 1'b1;
      end
      REQ_CAN_SHRINK: begin
        if (m_gd > 0) begin
          y.ok = 1'b1;
          for (int i = 0; i < size; i++)
            if (m_ld[i] >= m_gd) y.ok = 1'b0;
        end
      end
      default: ;
    endcase
    y.gd = m_gd;
    return y;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  function automatic dir_req_t mk_req(logic [REQ_W-1:0] req, logic [HASH_W-1:0] hash,
                                      logic [IDX_W-1:0] idx, logic signed [PID_W-1:0] pid,
                                      logic [LD_W-1:0] ld);
    dir_req_t r;
    r = '{req: req, hash: hash, idx: idx, pid: pid, ld: ld};
    return r;
  endfunction

  // Start is lowered or reloaded at the first falling edge after acceptance,
  // so an item is never taken twice.
  task automatic send_request(input dir_req_t r);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start          <= 1'b1;
    req_type_i     <= r.req;
    hash_i         <= r.hash;
    bucket_index_i <= r.idx;
    page_id_i      <= r.pid;
    local_depth_i  <= r.ld;
    do @(posedge clk_i); while (busy);
    dir_reply_q.push_back(apply_dir_request(r));
  endtask

  task automatic drain_replies();
    @(negedge clk_i);
    start <= 1'b0;
    while (dir_reply_q.size() != 0 || busy) @(posedge clk_i);
  endtask

  // The ceiling is only written with the directory idle.
  task automatic set_grow_lim(input logic [LD_W-1:0] v);
    drain_replies();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    m_grow_lim = v;
  endtask

  // ---------------------------------------------------------------------------
  // Reply checking
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    dir_reply_t e;
    if (rst_ni && done_o) begin
      if (dir_reply_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected reply: sts=%0d slot=%0d pid=%0d", status_o, out_slot_o,
                   out_page_id_o);
      end else begin
        e = dir_reply_q.pop_front();
        if (status_o !== e.sts || out_slot_o !== e.slot || out_page_id_o !== e.pid ||
            out_local_depth_o !== e.ld || split_image_o !== e.split ||
            cur_global_depth_o !== e.gd || shrink_ok_o !== e.ok) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("mismatch req=%0d exp sts=%0d slot=%0d pid=%0d ld=%0d split=%0d gd=%0d ok=%0d",
                     e.req, e.sts, e.slot, e.pid, e.ld, e.split, e.gd, e.ok);
            $display("               got sts=%0d slot=%0d pid=%0d ld=%0d split=%0d gd=%0d ok=%0d",
                     status_o, out_slot_o, out_page_id_o, out_local_depth_o,
                     split_image_o, cur_global_depth_o, shrink_ok_o);
          end
        end
      end
    end
  end

  // Watchdog: cycles with neither an accepted item nor a reply.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[extendible_hash_directory_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty directory, range flags, local depth saturation, unknown codes, clear.
  task automatic test_boundaries();
    send_request(mk_req(REQ_CAN_SHRINK, '0, '0, '0, '0));        // depth 0: no
    send_request(mk_req(REQ_SHRINK, '0, '0, '0, '0));            // depth 0: limit
    send_request(mk_req(REQ_LOOKUP, '1, '1, '1, '1));
    send_request(mk_req(REQ_READ, '0, 9'd511, '0, '0));          // beyond size
    send_request(mk_req(REQ_WRITE_ID, '0, 9'd0, 32'sh7fffffff, '0));
    send_request(mk_req(REQ_WRITE_ID, '0, 9'd511, 32'sh80000000, '0));
    send_request(mk_req(REQ_SET_LD, '0, 9'd0, '0, 4'd15));       // clipped to cap
    send_request(mk_req(REQ_INC_LD, '0, 9'd0, '0, '0));          // at cap
    send_request(mk_req(REQ_SET_LD, '0, 9'd0, '0, 4'd0));
    send_request(mk_req(REQ_DEC_LD, '0, 9'd0, '0, '0));          // at 0
    send_request(mk_req(REQ_INC_LD, '0, 9'd1, '0, '0));          // beyond size
    send_request(mk_req(REQ_GROW, '0, '0, '0, '0));
    send_request(mk_req(REQ_CAN_SHRINK, '0, '0, '0, '0));        // all below: yes
    send_request(mk_req(REQ_INC_LD, '0, 9'd1, '0, '0));
    send_request(mk_req(REQ_CAN_SHRINK, '0, '0, '0, '0));
    send_request(mk_req(REQ_LOOKUP, '1, '0, '0, '0));
    send_request(mk_req(REQ_UNKNOWN_LO, '1, '1, '1, '1));
    send_request(mk_req(REQ_UNKNOWN_HI, '0, '0, '0, '0));
    send_request(mk_req(REQ_CLEAR, '0, '0, '0, '0));
    send_request(mk_req(REQ_READ, '0, 9'd511, '0, '0));          // cleared contents
  endtask

  // Ceiling at zero, small caps, and a cap lowered below the global depth.
  task automatic test_depth_limits();
    set_grow_lim(4'd0);
    send_request(mk_req(REQ_GROW, '0, '0, '0, '0));
    send_request(mk_req(REQ_SET_LD, '0, 9'd0, '0, 4'd3));
    set_grow_lim(4'd2);
    repeat (3) send_request(mk_req(REQ_GROW, '0, '0, '0, '0));
    set_grow_lim(4'd1);
    send_request(mk_req(REQ_GROW, '0, '0, '0, '0));
    send_request(mk_req(REQ_INC_LD, '0, 9'd3, '0, '0));
  endtask

  function automatic logic [REQ_W-1:0] REQ_WIDTH_RANDOM_UNKNOWN();
    return REQ_W'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
  endfunction

  function automatic dir_req_t random_request(int ceiling);
    dir_req_t    r;
    int          w;
    int unsigned size;
    size = 1 << m_gd;
    r.hash = $urandom;
    r.pid  = ($urandom_range(0, 9) == 0) ? PID_INVALID : $signed($urandom);
    r.idx  = ($urandom_range(0, 3) != 0) ? IDX_W'($urandom_range(0, size - 1))
                                         : IDX_W'($urandom_range(0, DIR_ENTRIES - 1));
    case ($urandom_range(0, 2))
      0: r.ld = LD_W'($urandom_range(0, m_gd));
      1: r.ld = LD_W'($urandom_range(0, DEPTH_LIMIT));
      default: r.ld = LD_W'($urandom_range(0, 15));
    endcase
    w = $urandom_range(0, 99);
    if      (w < 18) r.req = REQ_LOOKUP;
    else if (w < 32) r.req = REQ_READ;
    else if (w < 46) r.req = REQ_WRITE_ID;
    else if (w < 56) r.req = REQ_SET_LD;
    else if (w < 66) r.req = REQ_INC_LD;
    else if (w < 74) r.req = REQ_DEC_LD;
    else if (w < 84) r.req = REQ_GROW;
    else if (w < 91) r.req = REQ_SHRINK;
    else if (w < 97) r.req = REQ_CAN_SHRINK;
    else if (w < 98) r.req = REQ_CLEAR;
    else r.req = REQ_WIDTH_RANDOM_UNKNOWN();
    // keep the directory small most of the time
    if (r.req == REQ_GROW && m_gd >= ceiling && $urandom_range(0, 3) != 0)
      r.req = REQ_SHRINK;
    return r;
  endfunction

  // Random traffic over several ceiling settings, with idle and burst stretches.
  task automatic test_random_traffic();
    int depth_set [7] = '{9, 15, 3, 0, 5, 2, 9};
    int ceiling   [7] = '{4, 9, 3, 0, 5, 5, 4};
    for (int p = 0; p < 7; p++) begin
      set_grow_lim(LD_W'(depth_set[p]));
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
        send_request(random_request(ceiling[p]));
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    m_grow_lim = GROW_LIM_RST;
    clear_directory();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_boundaries();
    test_depth_limits();
    test_random_traffic();

    drain_replies();
    repeat (16) @(posedge clk_i);
    if (dir_reply_q.size() != 0) err_cnt++;

    if (err_cnt == 0) begin
      $display("[extendible_hash_directory_core] OK");
    end else begin
      $display("[extendible_hash_directory_core] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
design/ehd_pkg.sv
design/extendible_hash_directory_core.sv
tb/tb_top.sv
